// ===== rtl/core/tgf_pkg.sv =====
// Shared constants, sine table and state type for the tone generator.
`default_nettype none
package tgf_pkg;

  localparam int SAMPLE_RATE_HZ   = 44100;
  localparam int MAX_NOTE_SAMPLES = 22050;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int AMP_SCALE = 28000;
  localparam int POLY_A    = 51472;
  localparam int POLY_B    = 21167;
  localparam int POLY_C    = 2463;

  // field widths
  localparam int FREQ_W = 15;
  localparam int MS_W   = 10;
  localparam int WAVE_W = 2;
  localparam int VOL_W  = 9;
  localparam int LEN_W  = 15;
  localparam int SMP_W  = 16;

  // serial datapath widths
  localparam int RATE_W  = $clog2(SAMPLE_RATE_HZ + 1);
  localparam int NPROD_W = MS_W + RATE_W;
  localparam int ACC_W   = 64;
  localparam int MCB_W   = 16;
  localparam int DV_W    = 20;
  localparam int CNT_W   = 6;
  localparam int DEC_W   = 36;
  localparam int MAG_W   = 16;

  // sine table indexing
  localparam int K_W    = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR    = SINE_TABLE_DEPTH / 4;
  localparam int IDX_W  = K_W - 1;
  localparam int U_STEP = 131072 / SINE_TABLE_DEPTH;

  localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_FALL   = 2'd2;

  typedef logic [14:0] qsin_tab_t [0:QTR];

  // quarter-wave Q15 polynomial, evaluated at elaboration
  function automatic qsin_tab_t qsin_build();
    qsin_tab_t tab;
    longint    u;
    longint    u2;
    longint    t;
    for (int j = 0; j <= QTR; j++) begin
      u  = longint'(j) * U_STEP;
      u2 = (u * u) >>> 15;
      t  = (POLY_C * u2) >>> 15;
      t  = POLY_B - t;
      t  = (t * u2) >>> 15;
      t  = POLY_A - t;
      t  = (t * u) >>> 15;
      if (t > 32767) t = 32767;
      tab[j] = t[14:0];
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN_TAB = qsin_build();

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NMUL,
    ST_NDIV,
    ST_FDIV,
    ST_PDIV,
    ST_DMUL,
    ST_DDIV,
    ST_SMUL1,
    ST_SMUL2,
    ST_SMUL3,
    ST_SDIV,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/tone_generator_with_fade.sv =====
// Top level: serial DDS tone generator with linear release.
`default_nettype none
//
// channel | dir | handshake          | payload
// --------+-----+--------------------+------------------------------------------
// in      | in  | in_tvalid/tready   | tuser=mode, tdata=freq,dur,wave,volume
// out     | out | out_tvalid/tready  | tdata=sample, tuser=active, tlast=last
//
// One word in flight at a time. A tick while idle goes straight to the
// done state. A tick during a note runs env, volume and amplitude
// products through a shift-add multiplier, then a restoring divider. A
// start word first sets up note length (multiply, divide), fade point
// and phase step (divides), and for the falling sine the glide decrement
// (multiply, divide), all through the same serial multiplier and divider.
// Reset is synchronous, active low, and leaves the generator idle. A
// result waits in the output register; a new word is accepted meanwhile
// and holds at the end if the output is still full.
module tone_generator_with_fade (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // freq_hz[14:0], duration_ms[24:15],
                                       // waveform[26:25], volume[35:27], zero pad
  input  wire logic        in_tuser,   // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // sample[15:0]
  output logic             out_tuser,  // active
  output logic             out_tlast   // last
);

  // input field slices
  logic [tgf_pkg::FREQ_W-1:0] in_freq;
  logic [tgf_pkg::MS_W-1:0]   in_ms;
  logic [tgf_pkg::WAVE_W-1:0] in_wave;
  logic [tgf_pkg::VOL_W-1:0]  in_vol;
  logic                       in_fire;

  assign in_freq = in_tdata[14:0];
  assign in_ms   = in_tdata[24:15];
  assign in_wave = in_tdata[26:25];
  assign in_vol  = in_tdata[35:27];

  // control
  tgf_pkg::state_t state_r, state_nxt;
  logic [tgf_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      cnt_last;
  logic                      done_fire;

  // note state
  logic [31:0]                phase_acc_r, phase_acc_nxt;
  logic [31:0]                phase_step_r, phase_step_nxt;
  logic [31:0]                step_dec_r, step_dec_nxt;
  logic [tgf_pkg::LEN_W-1:0]  sample_index_r, sample_index_nxt;
  logic [tgf_pkg::LEN_W-1:0]  note_length_r, note_length_nxt;
  logic [tgf_pkg::LEN_W-1:0]  fade_start_r, fade_start_nxt;
  logic [tgf_pkg::WAVE_W-1:0] wave_select_r, wave_select_nxt;
  logic [tgf_pkg::VOL_W-1:0]  note_volume_r, note_volume_nxt;
  logic [tgf_pkg::FREQ_W-1:0] freq_r, freq_nxt;
  logic                       note_active_r, note_active_nxt;

  // serial arithmetic
  logic [tgf_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [tgf_pkg::ACC_W-1:0] mca_r, mca_nxt;
  logic [tgf_pkg::MCB_W-1:0] mcb_r, mcb_nxt;
  logic [tgf_pkg::ACC_W-1:0] dq_r, dq_nxt;
  logic [tgf_pkg::DV_W-1:0]  rem_r, rem_nxt;
  logic [tgf_pkg::DV_W-1:0]  dvs_r, dvs_nxt;
  logic                      neg_r, neg_nxt;

  logic [tgf_pkg::ACC_W-1:0] mul_sum;
  logic [tgf_pkg::DV_W:0]    rem_sh;
  logic                      div_ge;
  logic [tgf_pkg::DV_W-1:0]  div_rem;
  logic [tgf_pkg::ACC_W-1:0] div_dq;

  // output register
  logic                       out_valid_r;
  logic [tgf_pkg::SMP_W-1:0]  out_sample_r, out_sample_nxt;
  logic                       out_active_r, out_active_nxt;
  logic                       out_last_r, out_last_nxt;

  assign in_tready  = (state_r == tgf_pkg::ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tuser  = out_active_r;
  assign out_tlast  = out_last_r;
  assign cnt_last   = (cnt_r == '0);
  assign done_fire  = (state_r == tgf_pkg::ST_DONE) && (!out_valid_r || out_tready);

  // one bit of multiply and of divide per cycle
  assign mul_sum = acc_r + (mcb_r[0] ? mca_r : '0);
  assign rem_sh  = {rem_r, dq_r[tgf_pkg::ACC_W-1]};
  assign div_ge  = rem_sh >= {1'b0, dvs_r};
  assign div_rem = div_ge ? tgf_pkg::DV_W'(rem_sh - {1'b0, dvs_r})
                          : rem_sh[tgf_pkg::DV_W-1:0];
  assign div_dq  = {dq_r[tgf_pkg::ACC_W-2:0], div_ge};

  // sine lookup on the current phase
  logic [tgf_pkg::K_W-1:0]   sin_k;
  logic [tgf_pkg::IDX_W-1:0] sin_idx;
  logic [14:0]               sin_s;
  logic                      sin_pos;
  logic [tgf_pkg::MAG_W-1:0] smp_mag;
  logic                      smp_neg;
  logic [tgf_pkg::LEN_W-1:0] smp_env;
  logic [tgf_pkg::LEN_W+2:0] fade_off;

  assign sin_k   = phase_acc_r[31 -: tgf_pkg::K_W];
  assign sin_idx = sin_k[tgf_pkg::K_W-2]
                 ? tgf_pkg::IDX_W'(tgf_pkg::QTR - int'(sin_k[tgf_pkg::K_W-3:0]))
                 : {1'b0, sin_k[tgf_pkg::K_W-3:0]};
  assign sin_s   = tgf_pkg::QSIN_TAB[sin_idx];
  assign sin_pos = (sin_s != '0) && !sin_k[tgf_pkg::K_W-1];

  // square uses full scale: positive only when the sine is strictly positive
  assign smp_mag = (wave_select_r == tgf_pkg::WAVE_SQUARE) ? 16'h8000 : {1'b0, sin_s};
  assign smp_neg = (wave_select_r == tgf_pkg::WAVE_SQUARE)
                 ? !sin_pos
                 : (sin_k[tgf_pkg::K_W-1] && (sin_s != '0));

  // release envelope numerator; stays positive inside a note
  assign fade_off = 18'(5 * (sample_index_r - fade_start_r));
  assign smp_env  = (sample_index_r > fade_start_r)
                  ? tgf_pkg::LEN_W'(note_length_r - fade_off[tgf_pkg::LEN_W-1:0])
                  : note_length_r;

  // saturated result from the quotient
  logic [31:0]               full_q;
  logic [tgf_pkg::SMP_W-1:0] res_sample;
  logic                      res_last;

  assign full_q = dq_r[31:0];
  always_comb begin
    if (!note_active_r) begin
      res_sample = '0;
    end else if (neg_r) begin
      res_sample = (full_q > 32'd32768) ? 16'h8000 : 16'(-full_q);
    end else begin
      res_sample = (full_q > 32'd32767) ? 16'h7fff : full_q[15:0];
    end
  end
  assign res_last = note_active_r &&
                    (({1'b0, sample_index_r} + 16'd1) >= {1'b0, note_length_r});

  // next state
  always_comb begin
    logic [tgf_pkg::NPROD_W-1:0] n_q;
    logic [tgf_pkg::LEN_W-1:0]   n_len;
    n_q       = div_dq[tgf_pkg::NPROD_W-1:0];
    n_len     = '0;
    state_nxt = state_r;
    unique case (state_r)
      tgf_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser) state_nxt = tgf_pkg::ST_NMUL;
          else if (note_active_r) state_nxt = tgf_pkg::ST_SMUL1;
          else state_nxt = tgf_pkg::ST_DONE;
        end
      end
      tgf_pkg::ST_NMUL:  if (cnt_last) state_nxt = tgf_pkg::ST_NDIV;
      tgf_pkg::ST_NDIV:  if (cnt_last) state_nxt = tgf_pkg::ST_FDIV;
      tgf_pkg::ST_FDIV:  if (cnt_last) state_nxt = tgf_pkg::ST_PDIV;
      tgf_pkg::ST_PDIV: begin
        if (cnt_last) begin
          if (note_length_r == '0) state_nxt = tgf_pkg::ST_DONE;
          else if (wave_select_r == tgf_pkg::WAVE_FALL) state_nxt = tgf_pkg::ST_DMUL;
          else state_nxt = tgf_pkg::ST_SMUL1;
        end
      end
      tgf_pkg::ST_DMUL:  if (cnt_last) state_nxt = tgf_pkg::ST_DDIV;
      tgf_pkg::ST_DDIV:  if (cnt_last) state_nxt = tgf_pkg::ST_SMUL1;
      tgf_pkg::ST_SMUL1: if (cnt_last) state_nxt = tgf_pkg::ST_SMUL2;
      tgf_pkg::ST_SMUL2: if (cnt_last) state_nxt = tgf_pkg::ST_SMUL3;
      tgf_pkg::ST_SMUL3: if (cnt_last) state_nxt = tgf_pkg::ST_SDIV;
      tgf_pkg::ST_SDIV:  if (cnt_last) state_nxt = tgf_pkg::ST_DONE;
      tgf_pkg::ST_DONE:  if (done_fire) state_nxt = tgf_pkg::ST_IDLE;
      default:           state_nxt = tgf_pkg::ST_IDLE;
    endcase
    if (n_q > tgf_pkg::NPROD_W'(tgf_pkg::MAX_NOTE_SAMPLES)) n_len = tgf_pkg::LEN_W'(tgf_pkg::MAX_NOTE_SAMPLES);
    else n_len = n_q[tgf_pkg::LEN_W-1:0];
    note_length_nxt = note_length_r;
    if (state_r == tgf_pkg::ST_NDIV && cnt_last) note_length_nxt = n_len;
  end

  // datapath and outputs
  always_comb begin
    logic [31:0]                 ps_q;
    logic [tgf_pkg::ACC_W-1:0]   sm_load_mca;
    logic [tgf_pkg::DV_W-1:0]    n5;
    logic [tgf_pkg::DV_W-1:0]    n10;
    ps_q        = div_dq[31:0];
    sm_load_mca = {{(tgf_pkg::ACC_W-tgf_pkg::MAG_W){1'b0}}, smp_mag};
    n5          = tgf_pkg::DV_W'(5 * int'(note_length_r));
    n10         = tgf_pkg::DV_W'(10 * int'(note_length_r));

    cnt_nxt          = cnt_r;
    acc_nxt          = acc_r;
    mca_nxt          = mca_r;
    mcb_nxt          = mcb_r;
    dq_nxt           = dq_r;
    rem_nxt          = rem_r;
    dvs_nxt          = dvs_r;
    neg_nxt          = neg_r;
    phase_acc_nxt    = phase_acc_r;
    phase_step_nxt   = phase_step_r;
    step_dec_nxt     = step_dec_r;
    sample_index_nxt = sample_index_r;
    fade_start_nxt   = fade_start_r;
    wave_select_nxt  = wave_select_r;
    note_volume_nxt  = note_volume_r;
    freq_nxt         = freq_r;
    note_active_nxt  = note_active_r;
    out_sample_nxt   = out_sample_r;
    out_active_nxt   = out_active_r;
    out_last_nxt     = out_last_r;

    // shared per-cycle steps
    unique case (state_r)
      tgf_pkg::ST_NMUL, tgf_pkg::ST_DMUL, tgf_pkg::ST_SMUL1, tgf_pkg::ST_SMUL2,
      tgf_pkg::ST_SMUL3: begin
        acc_nxt = mul_sum;
        mca_nxt = {mca_r[tgf_pkg::ACC_W-2:0], 1'b0};
        mcb_nxt = {1'b0, mcb_r[tgf_pkg::MCB_W-1:1]};
        cnt_nxt = cnt_r - 1'b1;
      end
      tgf_pkg::ST_NDIV, tgf_pkg::ST_FDIV, tgf_pkg::ST_PDIV, tgf_pkg::ST_DDIV,
      tgf_pkg::ST_SDIV: begin
        dq_nxt  = div_dq;
        rem_nxt = div_rem;
        cnt_nxt = cnt_r - 1'b1;
      end
      tgf_pkg::ST_IDLE, tgf_pkg::ST_DONE: ;
      default: ;
    endcase

    unique case (state_r)
      tgf_pkg::ST_IDLE: begin
        if (in_fire && in_tuser) begin
          freq_nxt        = in_freq;
          wave_select_nxt = in_wave;
          note_volume_nxt = in_vol;
          acc_nxt         = '0;
          mca_nxt         = tgf_pkg::ACC_W'(tgf_pkg::SAMPLE_RATE_HZ);
          mcb_nxt         = tgf_pkg::MCB_W'(in_ms);
          cnt_nxt         = tgf_pkg::CNT_W'(tgf_pkg::MS_W - 1);
        end else if (in_fire && note_active_r) begin
          acc_nxt = '0;
          mca_nxt = sm_load_mca;
          mcb_nxt = tgf_pkg::MCB_W'(smp_env);
          neg_nxt = smp_neg;
          cnt_nxt = tgf_pkg::CNT_W'(tgf_pkg::LEN_W - 1);
        end
      end
      tgf_pkg::ST_NMUL: begin
        if (cnt_last) begin
          dq_nxt  = {mul_sum[tgf_pkg::NPROD_W-1:0],
                     {(tgf_pkg::ACC_W-tgf_pkg::NPROD_W){1'b0}}};
          rem_nxt = '0;
          dvs_nxt = tgf_pkg::DV_W'(1000);
          cnt_nxt = tgf_pkg::CNT_W'(tgf_pkg::NPROD_W - 1);
        end
      end
      tgf_pkg::ST_NDIV: begin
        if (cnt_last) begin
          // four fifths of the length marks the start of the release
          dq_nxt           = {note_length_nxt, 2'b00,
                              {(tgf_pkg::ACC_W-tgf_pkg::LEN_W-2){1'b0}}};
          rem_nxt          = '0;
          dvs_nxt          = tgf_pkg::DV_W'(5);
          cnt_nxt          = tgf_pkg::CNT_W'(tgf_pkg::LEN_W + 1);
          phase_acc_nxt    = '0;
          sample_index_nxt = '0;
        end
      end
      tgf_pkg::ST_FDIV: begin
        if (cnt_last) begin
          fade_start_nxt = div_dq[tgf_pkg::LEN_W-1:0];
          // rounded freq * 2^32 / rate
          dq_nxt  = {freq_r, 32'(tgf_pkg::SAMPLE_RATE_HZ / 2),
                     {(tgf_pkg::ACC_W-tgf_pkg::FREQ_W-32){1'b0}}};
          rem_nxt = '0;
          dvs_nxt = tgf_pkg::DV_W'(tgf_pkg::SAMPLE_RATE_HZ);
          cnt_nxt = tgf_pkg::CNT_W'(tgf_pkg::FREQ_W + 31);
        end
      end
      tgf_pkg::ST_PDIV: begin
        if (cnt_last) begin
          phase_step_nxt  = ps_q;
          step_dec_nxt    = '0;
          note_active_nxt = (note_length_r != '0);
          if (note_length_r != '0 && wave_select_r == tgf_pkg::WAVE_FALL) begin
            // 7*step + 5n, later divided by 10n
            acc_nxt = tgf_pkg::ACC_W'(n5);
            mca_nxt = {32'd0, ps_q};
            mcb_nxt = tgf_pkg::MCB_W'(7);
            cnt_nxt = tgf_pkg::CNT_W'(2);
          end else begin
            acc_nxt = '0;
            mca_nxt = sm_load_mca;
            mcb_nxt = tgf_pkg::MCB_W'(smp_env);
            neg_nxt = smp_neg;
            cnt_nxt = tgf_pkg::CNT_W'(tgf_pkg::LEN_W - 1);
          end
        end
      end
      tgf_pkg::ST_DMUL: begin
        if (cnt_last) begin
          dq_nxt  = {mul_sum[tgf_pkg::DEC_W-1:0], {(tgf_pkg::ACC_W-tgf_pkg::DEC_W){1'b0}}};
          rem_nxt = '0;
          dvs_nxt = n10;
          cnt_nxt = tgf_pkg::CNT_W'(tgf_pkg::DEC_W - 1);
        end
      end
      tgf_pkg::ST_DDIV: begin
        if (cnt_last) begin
          step_dec_nxt = div_dq[31:0];
          acc_nxt      = '0;
          mca_nxt      = sm_load_mca;
          mcb_nxt      = tgf_pkg::MCB_W'(smp_env);
          neg_nxt      = smp_neg;
          cnt_nxt      = tgf_pkg::CNT_W'(tgf_pkg::LEN_W - 1);
        end
      end
      tgf_pkg::ST_SMUL1: begin
        if (cnt_last) begin
          acc_nxt = '0;
          mca_nxt = mul_sum;
          mcb_nxt = tgf_pkg::MCB_W'(note_volume_r);
          cnt_nxt = tgf_pkg::CNT_W'(tgf_pkg::VOL_W - 1);
        end
      end
      tgf_pkg::ST_SMUL2: begin
        if (cnt_last) begin
          acc_nxt = '0;
          mca_nxt = mul_sum;
          mcb_nxt = tgf_pkg::MCB_W'(tgf_pkg::AMP_SCALE);
          cnt_nxt = tgf_pkg::CNT_W'(14);
        end
      end
      tgf_pkg::ST_SMUL3: begin
        if (cnt_last) begin
          // drop the 2^23 of Q15 and Q1.8, then divide by the note length
          dq_nxt  = {mul_sum[54:23], 32'd0};
          rem_nxt = '0;
          dvs_nxt = tgf_pkg::DV_W'(note_length_r);
          cnt_nxt = tgf_pkg::CNT_W'(31);
        end
      end
      tgf_pkg::ST_SDIV: ;
      tgf_pkg::ST_DONE: begin
        if (done_fire) begin
          out_sample_nxt = res_sample;
          out_active_nxt = note_active_r;
          out_last_nxt   = res_last;
          if (note_active_r) begin
            phase_acc_nxt    = phase_acc_r + phase_step_r;
            phase_step_nxt   = (phase_step_r > step_dec_r) ? phase_step_r - step_dec_r : '0;
            sample_index_nxt = sample_index_r + 1'b1;
            if (res_last) note_active_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= tgf_pkg::ST_IDLE;
      out_valid_r    <= 1'b0;
      note_active_r  <= 1'b0;
      phase_acc_r    <= '0;
      phase_step_r   <= '0;
      step_dec_r     <= '0;
      sample_index_r <= '0;
      note_length_r  <= '0;
      fade_start_r   <= '0;
      wave_select_r  <= '0;
      note_volume_r  <= '0;
    end else begin
      state_r        <= state_nxt;
      note_active_r  <= note_active_nxt;
      phase_acc_r    <= phase_acc_nxt;
      phase_step_r   <= phase_step_nxt;
      step_dec_r     <= step_dec_nxt;
      sample_index_r <= sample_index_nxt;
      note_length_r  <= note_length_nxt;
      fade_start_r   <= fade_start_nxt;
      wave_select_r  <= wave_select_nxt;
      note_volume_r  <= note_volume_nxt;
      if (done_fire) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    acc_r        <= acc_nxt;
    mca_r        <= mca_nxt;
    mcb_r        <= mcb_nxt;
    dq_r         <= dq_nxt;
    rem_r        <= rem_nxt;
    dvs_r        <= dvs_nxt;
    neg_r        <= neg_nxt;
    freq_r       <= freq_nxt;
    out_sample_r <= out_sample_nxt;
    out_active_r <= out_active_nxt;
    out_last_r   <= out_last_nxt;
  end

  // checks
  a_last_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser)
    else $error("last word without an active note");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("nonzero sample while idle");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    note_active_r && state_r == tgf_pkg::ST_IDLE |-> sample_index_r < note_length_r)
    else $error("sample index past note end");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    done_fire && res_last |=> !note_active_r)
    else $error("note still active after its last sample");

endmodule
`default_nettype wire
